/* hw/rtl/ile_pkg.sv */
// ----------------------------------------------------------------------------
// ile_pkg
// Shared types and constants for the indexed list engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ile_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LEN_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 12;
  localparam int MAG_W    = POS_W - 1;
  localparam int CMP_W    = (LEN_W > MAG_W) ? LEN_W : MAG_W;
  localparam int VAL_W    = 32;
  localparam int OLEN_W   = 11;

  localparam logic signed [VAL_W-1:0] READ_MISS = -32'sd1;

  typedef enum logic [2:0] {
    CMD_READ   = 3'd0,
    CMD_HEAD   = 3'd1,
    CMD_TAIL   = 3'd2,
    CMD_BEFORE = 3'd3,
    CMD_DELETE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_SNAP,
    OP_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t                 op;
    logic [IDX_W-1:0]         index;
    logic signed [VAL_W-1:0]  value;
  } cell_ctrl_t;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

endpackage

`default_nettype wire

/* hw/rtl/ile_cell.sv */
// ----------------------------------------------------------------------------
// ile_cell
// One list slot: holds an element and a read-bus stage, shifts with its
// neighbors on insert, delete and readout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ile_cell (
  input  wire logic                              clk,
  input  wire ile_pkg::cell_ctrl_t               ctrl,
  input  wire logic [ile_pkg::IDX_W-1:0]         my_index,
  input  wire logic signed [ile_pkg::VAL_W-1:0]  left_data,
  input  wire logic signed [ile_pkg::VAL_W-1:0]  right_data,
  input  wire logic signed [ile_pkg::VAL_W-1:0]  right_bus,
  output logic signed [ile_pkg::VAL_W-1:0]       data,
  output logic signed [ile_pkg::VAL_W-1:0]       bus
);
  import ile_pkg::*;

  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_INSERT: begin
        if (my_index > ctrl.index) begin
          data <= left_data;
        end else if (my_index == ctrl.index) begin
          data <= ctrl.value;
        end
      end
      OP_DELETE: begin
        if (my_index >= ctrl.index) begin
          data <= right_data;
        end
      end
      OP_SNAP: begin
        bus <= data;
      end
      OP_SHIFT: begin
        bus <= right_bus;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

/* hw/rtl/ile_chain.sv */
// ----------------------------------------------------------------------------
// ile_chain
// Row of CAPACITY cells with neighbor links; cell 0 drives the read bus out.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ile_chain (
  input  wire logic                              clk,
  input  wire ile_pkg::cell_ctrl_t               ctrl,
  output logic signed [ile_pkg::VAL_W-1:0]       head_bus
);
  import ile_pkg::*;

  logic signed [VAL_W-1:0] data [CAPACITY];
  logic signed [VAL_W-1:0] bus  [CAPACITY];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VAL_W-1:0] left_d;
    logic signed [VAL_W-1:0] right_d;
    logic signed [VAL_W-1:0] right_b;

    if (i == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_mid_l
      assign left_d = data[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_d = '0;
      assign right_b = '0;
    end else begin : g_mid_r
      assign right_d = data[i+1];
      assign right_b = bus[i+1];
    end

    ile_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .my_index   (IDX_W'(i)),
      .left_data  (left_d),
      .right_data (right_d),
      .right_bus  (right_b),
      .data       (data[i]),
      .bus        (bus[i])
    );
  end

  assign head_bus = bus[0];

endmodule

`default_nettype wire

/* hw/rtl/indexed_list_engine.sv */
// ----------------------------------------------------------------------------
// indexed_list_engine
// Ordered list of signed 32-bit values held in a chain of cells, with
// indexed read, insert and delete.
// ----------------------------------------------------------------------------
//  channel | signals                                   | dir
//  in      | in_valid in_ready cmd position item_value | in
//  out     | out_valid out_ready read_value status     | out
//          | length_after                              |
//
//  Insert, delete and rejected items: result registered on acceptance; on an
//  accepted insert or delete the cells at and beyond the index shift or load.
//  Valid read at position p: cells copy to the read bus, which then shifts
//  toward cell 0 one cell per cycle; no new item is taken until it is done.
//  A new item is taken once the result register is empty or being drained.
//  Reset clears the length and handshake state; cell contents are not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module indexed_list_engine (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [2:0]                          cmd,
  input  wire logic signed [ile_pkg::POS_W-1:0]    position,
  input  wire logic signed [ile_pkg::VAL_W-1:0]    item_value,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic signed [ile_pkg::VAL_W-1:0]         read_value,
  output logic [1:0]                               status,
  output logic [ile_pkg::OLEN_W-1:0]               length_after
);
  import ile_pkg::*;

  state_t                  state, state_next;
  logic [LEN_W-1:0]        len, len_next;
  logic [IDX_W-1:0]        cnt, cnt_next;
  cell_ctrl_t              ctrl;
  logic signed [VAL_W-1:0] head_bus;

  logic                    fire;
  logic                    out_load;
  logic signed [VAL_W-1:0] rd_next;
  status_t                 st_next;

  logic                    pos_neg;
  logic [CMP_W-1:0]        pos_w;
  logic [CMP_W-1:0]        len_w;
  logic                    in_range;
  logic                    ins_over;
  logic                    full;
  logic [IDX_W-1:0]        pos_idx;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);
  assign fire     = in_valid && in_ready;

  assign pos_neg  = position[POS_W-1];
  assign pos_w    = CMP_W'(position[MAG_W-1:0]);
  assign len_w    = CMP_W'(len);
  assign in_range = !pos_neg && (pos_w < len_w);
  assign ins_over = !pos_neg && (pos_w > len_w);
  assign full     = (len == LEN_W'(CAPACITY));
  assign pos_idx  = IDX_W'(position[MAG_W-1:0]);

  ile_chain u_chain (
    .clk      (clk),
    .ctrl     (ctrl),
    .head_bus (head_bus)
  );

  always_comb begin
    state_next = state;
    len_next   = len;
    cnt_next   = cnt;
    out_load   = 1'b0;
    rd_next    = '0;
    st_next    = ST_DONE;
    ctrl.op    = OP_HOLD;
    ctrl.index = pos_idx;
    ctrl.value = item_value;

    case (state)
      S_IDLE: begin
        if (fire) begin
          out_load = 1'b1;
          case (cmd_t'(cmd))
            CMD_READ: begin
              if (in_range) begin
                out_load   = 1'b0;
                ctrl.op    = OP_SNAP;
                cnt_next   = pos_idx;
                state_next = S_READ;
              end else begin
                rd_next = READ_MISS;
                st_next = ST_INVALID;
              end
            end
            CMD_HEAD: begin
              if (full) begin
                st_next = ST_FULL;
              end else begin
                ctrl.op    = OP_INSERT;
                ctrl.index = '0;
                len_next   = len + 1'b1;
              end
            end
            CMD_TAIL: begin
              if (full) begin
                st_next = ST_FULL;
              end else begin
                ctrl.op    = OP_INSERT;
                ctrl.index = IDX_W'(len);
                len_next   = len + 1'b1;
              end
            end
            CMD_BEFORE: begin
              if (ins_over) begin
                st_next = ST_INVALID;
              end else if (full) begin
                st_next = ST_FULL;
              end else begin
                ctrl.op    = OP_INSERT;
                ctrl.index = pos_neg ? '0 : pos_idx;
                len_next   = len + 1'b1;
              end
            end
            CMD_DELETE: begin
              if (in_range) begin
                ctrl.op  = OP_DELETE;
                len_next = len - 1'b1;
              end else begin
                st_next = ST_INVALID;
              end
            end
            default: begin
              st_next = ST_INVALID;
            end
          endcase
        end
      end
      S_READ: begin
        if (cnt == '0) begin
          out_load   = 1'b1;
          rd_next    = head_bus;
          state_next = S_IDLE;
        end else begin
          ctrl.op  = OP_SHIFT;
          cnt_next = cnt - 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      len       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      len   <= len_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt <= cnt_next;
    if (out_load) begin
      read_value   <= rd_next;
      status       <= st_next;
      length_after <= OLEN_W'(len_next);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ile_checker.sv */
// ----------------------------------------------------------------------------
// ile_checker
// Port-level checks on the indexed list engine, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ile_checker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  input  wire logic                                in_ready,
  input  wire logic                                out_valid,
  input  wire logic                                out_ready,
  input  wire logic signed [ile_pkg::VAL_W-1:0]    read_value,
  input  wire logic [1:0]                          status,
  input  wire logic [ile_pkg::OLEN_W-1:0]          length_after
);
  import ile_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_value)
      && $stable(status) && $stable(length_after))
    else $error("result changed while stalled");

  a_full_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> length_after == OLEN_W'(CAPACITY))
    else $error("full status with list not at capacity");

  a_rd_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_DONE) && (read_value != READ_MISS)
      |-> read_value == '0)
    else $error("rejected item carries a read value");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid || !in_ready)
    else $error("new item taken before result produced");

  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("undefined status code");

endmodule

bind indexed_list_engine ile_checker u_ile_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .read_value   (read_value),
  .status       (status),
  .length_after (length_after)
);

`default_nettype wire
